// ----- rtl/pacd_pkg.sv -----
// ============================================================================
// pacd_pkg
// Shared types and constants of the polygon area, centroid and diameter unit.
// ============================================================================
package pacd_pkg;

    localparam int COORD_W  = 16;
    localparam int PROD_W   = 2 * COORD_W;        // one coordinate product
    localparam int CROSS_W  = PROD_W + 1;         // one shoelace cross term
    localparam int SUM_W    = COORD_W + 1;        // sum of two coordinates
    localparam int MPROD_W  = SUM_W + CROSS_W;    // one moment term
    localparam int CSUM_W   = 40;                 // running cross sum
    localparam int MSUM_W   = 58;                 // running moment sums
    localparam int DEN_W    = CSUM_W + 2;         // three times the cross sum
    localparam int AREA_W   = 35;
    localparam int DIAM_W   = 17;
    localparam int D2_W     = 2 * DIAM_W;         // squared distance
    localparam int DIV_N_W  = MSUM_W + 2;         // 2|num| + |den|
    localparam int DIV_D_W  = DEN_W + 1;          // 2|den|
    localparam int DIV_CNT_W = $clog2(DIV_N_W);
    localparam int SQRT_CNT_W = $clog2(DIAM_W);
    localparam int SQRT_REM_W = DIAM_W + 3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DEGEN    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CROSS,
        S_MOM,
        S_ACC,
        S_SCAN,
        S_SQRT,
        S_DIVX,
        S_DIVY,
        S_OUT
    } state_t;

endpackage

// ----- rtl/polygon_area_centroid_diameter.sv -----
// ============================================================================
// polygon_area_centroid_diameter
// Shoelace area, centroid and vertex diameter of one polygon per frame.
// ============================================================================
// Vertices of a polygon arrive one per input transfer as signed Q2.14 x and y,
// with tlast on the final vertex. Each vertex up to MAX_VERTICES is written
// into the vertex memory in the accepting cycle, and the edge from the
// previous vertex then goes through a four-step multiply and accumulate
// sequence (coordinate products, cross term, moment products, sums). After
// the last vertex the closing edge goes through the same four steps; then,
// unless the polygon overflowed, the finishing work runs once per polygon:
// a pairwise scan over the vertex memory (one pair per cycle, n(n-1)/2
// pairs), a square root of the largest squared distance (17 result bits)
// and, for a proper polygon, two divisions (60 quotient bits each) for the
// centroid coordinates. One result transfer follows per polygon; the result
// register holds it until it is taken, and no vertex is accepted from the
// end of the last vertex until the result has been handed to the result
// register. Status 2 is reported when more than MAX_VERTICES vertices
// arrived (all numbers zero), status 1 for fewer than three vertices or zero
// area (centroid zero).
module polygon_area_centroid_diameter #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input vertex stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // vertex_x[15:0], vertex_y[31:16]
    input  logic        s_tlast,   // last_vertex
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // twice_area[34:0], centroid_x[50:35],
                                   // centroid_y[66:51], diameter[83:67],
                                   // status[85:84], zero[87:86]
);
    import pacd_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    state_t state_reg, state_next;

    // polygon accumulation state
    logic [CW-1:0]             count_reg;
    logic                      overflow_reg;
    logic signed [CSUM_W-1:0]  cross_reg;
    logic signed [MSUM_W-1:0]  mom_x_reg;
    logic signed [MSUM_W-1:0]  mom_y_reg;
    logic                      last_pending_reg;
    logic                      closing_reg;
    vertex_t                   prev_reg;
    vertex_t                   first_reg;

    // edge datapath
    vertex_t                   ea_reg;
    vertex_t                   eb_reg;
    logic signed [PROD_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0]  p2_reg;
    logic signed [CROSS_W-1:0] c_reg;
    logic signed [SUM_W-1:0]   sx_reg;
    logic signed [SUM_W-1:0]   sy_reg;
    logic signed [MPROD_W-1:0] mx_reg;
    logic signed [MPROD_W-1:0] my_reg;

    // diameter scan
    logic [AW-1:0]             scan_i_reg;
    logic [AW-1:0]             scan_j_reg;
    logic                      issue_reg;
    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic [PROD_W-1:0]         sqx_reg;
    logic [PROD_W-1:0]         sqy_reg;
    logic [D2_W-1:0]           best_reg;

    // results
    logic [DIAM_W-1:0]         diam_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic [1:0]                status_reg;
    logic                      m_valid_reg;
    logic [87:0]               m_data_reg;

    vertex_t in_vertex;
    vertex_t rd_a;
    vertex_t rd_b;
    logic    s_fire;
    logic    mem_we;
    logic    scan_done;
    logic    degenerate;
    logic    sqrt_start;
    logic    sqrt_done;
    logic [DIAM_W-1:0] sqrt_root;
    logic    div_start;
    logic    div_done;
    logic signed [COORD_W-1:0] div_result;
    logic signed [DEN_W-1:0]   den3;
    logic [CW-1:0]  count_m1;
    logic [CW-1:0]  count_m2;
    logic           j_at_end;
    logic           i_at_end;
    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic [CSUM_W-1:0] area_mag;
    logic [AREA_W-1:0] area_sat;
    logic           out_free;

    assign in_vertex.x = s_tdata[15:0];
    assign in_vertex.y = s_tdata[31:16];
    assign s_tready    = (state_reg == S_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign mem_we      = s_fire && (count_reg < CW'(MAX_VERTICES));
    assign out_free    = !m_valid_reg || m_tready;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign j_at_end = (CW'(scan_j_reg) == count_m1);
    assign i_at_end = (CW'(scan_i_reg) == count_m2);
    assign scan_done = !issue_reg && !s1_valid_reg && !s2_valid_reg;
    assign degenerate = (count_reg < CW'(3)) || (cross_reg == '0);
    assign den3 = (DEN_W'(cross_reg) <<< 1) + DEN_W'(cross_reg);

    assign dx = SUM_W'(rd_a.x) - SUM_W'(rd_b.x);
    assign dy = SUM_W'(rd_a.y) - SUM_W'(rd_b.y);

    assign area_mag = cross_reg[CSUM_W-1] ? CSUM_W'(-cross_reg) : CSUM_W'(cross_reg);
    assign area_sat = (area_mag[CSUM_W-1:AREA_W] != '0) ? {AREA_W{1'b1}}
                                                        : area_mag[AREA_W-1:0];

    pacd_vertex_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   (count_reg[AW-1:0]),
        .wr_data   (in_vertex),
        .rd_addr_a (scan_i_reg),
        .rd_addr_b (scan_j_reg),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    pacd_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (best_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // The single divider serves x first, then y.
    pacd_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    ((state_reg == S_DIVX) ? mom_y_reg : mom_x_reg),
        .den    (den3),
        .done   (div_done),
        .result (div_result)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (mem_we && (count_reg != '0))
                    begin
                        state_next = S_MUL;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:   state_next = S_CROSS;
            S_CROSS: state_next = S_MOM;
            S_MOM:   state_next = S_ACC;
            S_ACC:
            begin
                if (closing_reg)
                begin
                    state_next = overflow_reg ? S_OUT : S_SCAN;
                end
                else if (last_pending_reg)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    if (degenerate)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVX;
                    end
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            cross_reg        <= '0;
            mom_x_reg        <= '0;
            mom_y_reg        <= '0;
            last_pending_reg <= 1'b0;
            closing_reg      <= 1'b0;
            issue_reg        <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            // A new result may replace the one being taken in the same cycle.
            if ((state_reg == S_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            s1_valid_reg <= issue_reg;
            s2_valid_reg <= s1_valid_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        last_pending_reg <= s_tlast;
                        if (mem_we)
                        begin
                            count_reg <= count_reg + CW'(1);
                            // The very first vertex has no edge: with tlast it
                            // goes straight to the closing edge onto itself.
                            closing_reg <= (count_reg == '0) && s_tlast;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                            closing_reg  <= s_tlast;
                        end
                    end
                end
                S_ACC:
                begin
                    cross_reg <= cross_reg + CSUM_W'(c_reg);
                    mom_x_reg <= mom_x_reg + MSUM_W'(mx_reg);
                    mom_y_reg <= mom_y_reg + MSUM_W'(my_reg);
                    if (!closing_reg && last_pending_reg)
                    begin
                        closing_reg <= 1'b1;
                    end
                    if (closing_reg && !overflow_reg)
                    begin
                        issue_reg <= (count_reg >= CW'(2));
                    end
                end
                S_SCAN:
                begin
                    if (issue_reg && j_at_end && i_at_end)
                    begin
                        issue_reg <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        count_reg        <= '0;
                        overflow_reg     <= 1'b0;
                        cross_reg        <= '0;
                        mom_x_reg        <= '0;
                        mom_y_reg        <= '0;
                        last_pending_reg <= 1'b0;
                        closing_reg      <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (mem_we)
                    begin
                        prev_reg <= in_vertex;
                        if (count_reg == '0)
                        begin
                            first_reg <= in_vertex;
                            ea_reg    <= in_vertex;
                        end
                        else
                        begin
                            ea_reg <= prev_reg;
                        end
                        eb_reg <= in_vertex;
                    end
                    else
                    begin
                        ea_reg <= prev_reg;
                        eb_reg <= first_reg;
                    end
                end
            end
            S_MUL:
            begin
                p1_reg <= ea_reg.x * eb_reg.y;
                p2_reg <= eb_reg.x * ea_reg.y;
                sx_reg <= SUM_W'(ea_reg.x) + SUM_W'(eb_reg.x);
                sy_reg <= SUM_W'(ea_reg.y) + SUM_W'(eb_reg.y);
            end
            S_CROSS:
            begin
                c_reg <= CROSS_W'(p1_reg) - CROSS_W'(p2_reg);
            end
            S_MOM:
            begin
                mx_reg <= sx_reg * c_reg;
                my_reg <= sy_reg * c_reg;
            end
            S_ACC:
            begin
                // closing edge runs from the last stored vertex to the first
                ea_reg     <= prev_reg;
                eb_reg     <= first_reg;
                scan_i_reg <= '0;
                scan_j_reg <= AW'(1);
                best_reg   <= '0;
                diam_reg   <= '0;
                cx_reg     <= '0;
                cy_reg     <= '0;
            end
            S_SCAN:
            begin
                if (issue_reg)
                begin
                    if (j_at_end)
                    begin
                        if (!i_at_end)
                        begin
                            scan_i_reg <= scan_i_reg + AW'(1);
                            scan_j_reg <= scan_i_reg + AW'(2);
                        end
                    end
                    else
                    begin
                        scan_j_reg <= scan_j_reg + AW'(1);
                    end
                end
                if (s1_valid_reg)
                begin
                    sqx_reg <= PROD_W'(D2_W'(dx) * D2_W'(dx));
                    sqy_reg <= PROD_W'(D2_W'(dy) * D2_W'(dy));
                end
                if (s2_valid_reg)
                begin
                    if ((D2_W'(sqx_reg) + D2_W'(sqy_reg)) > best_reg)
                    begin
                        best_reg <= D2_W'(sqx_reg) + D2_W'(sqy_reg);
                    end
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    diam_reg <= sqrt_root;
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    cx_reg <= div_result;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    cy_reg <= div_result;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (overflow_reg)
                    begin
                        m_data_reg <= {2'b00, STATUS_OVERFLOW, {DIAM_W{1'b0}},
                                       {COORD_W{1'b0}}, {COORD_W{1'b0}},
                                       {AREA_W{1'b0}}};
                    end
                    else
                    begin
                        m_data_reg <= {2'b00, status_reg, diam_reg, cy_reg, cx_reg,
                                       area_sat};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status_reg = degenerate ? STATUS_DEGEN : STATUS_OK;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_scan_needs_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> (count_reg >= CW'(2)))
        else $error("pair scan issued with fewer than two vertices");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_data_reg[85:84] == STATUS_OVERFLOW))
            |-> (m_data_reg[83:0] == '0))
        else $error("overflow result carries non-zero numbers");

endmodule

// ----- rtl/pacd_vertex_mem.sv -----
// ============================================================================
// pacd_vertex_mem
// Vertex store: one write port, two registered read ports.
// ============================================================================
module pacd_vertex_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  pacd_pkg::vertex_t wr_data,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output pacd_pkg::vertex_t rd_data_a,
    output pacd_pkg::vertex_t rd_data_b
);
    import pacd_pkg::*;

    vertex_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- rtl/pacd_divider.sv -----
// ============================================================================
// pacd_divider
// Restoring divider, one quotient bit per cycle, rounded and saturated result.
// ============================================================================
module pacd_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pacd_pkg::MSUM_W-1:0]  num,
    input  logic signed [pacd_pkg::DEN_W-1:0]   den,
    output logic                                done,
    output logic signed [pacd_pkg::COORD_W-1:0] result
);
    import pacd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W:0]     rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic signed [COORD_W-1:0] result_reg;

    logic [MSUM_W-1:0]  num_mag;
    logic [DEN_W-1:0]   den_mag;
    logic [DIV_D_W:0]   rem_sh;
    logic               qbit;
    logic [DIV_D_W:0]   rem_new;
    logic [DIV_N_W-1:0] quo_new;

    assign num_mag = num[MSUM_W-1] ? MSUM_W'(-num) : MSUM_W'(num);
    assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    always_comb
    begin
        rem_sh  = {rem_reg[DIV_D_W-1:0], num_reg[DIV_N_W-1]};
        qbit    = (rem_sh >= {1'b0, den_reg});
        rem_new = qbit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        quo_new = {quo_reg[DIV_N_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {1'b0, num_mag, 1'b0} + DIV_N_W'(den_mag);
            den_reg <= {den_mag, 1'b0};
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= num[MSUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_N_W-2:0], 1'b0};
            rem_reg <= rem_new;
            quo_reg <= quo_new;
            if (cnt_reg == '0)
            begin
                if (neg_reg)
                begin
                    result_reg <= (quo_new > DIV_N_W'(32768)) ? COORD_W'(-32768)
                                                             : COORD_W'(-quo_new);
                end
                else
                begin
                    result_reg <= (quo_new > DIV_N_W'(32767)) ? COORD_W'(32767)
                                                             : COORD_W'(quo_new);
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/pacd_isqrt.sv -----
// ============================================================================
// pacd_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ============================================================================
module pacd_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pacd_pkg::D2_W-1:0]        value,
    output logic                             done,
    output logic [pacd_pkg::DIAM_W-1:0]      root
);
    import pacd_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [D2_W-1:0]       val_reg;
    logic [SQRT_REM_W-1:0] rem_reg;
    logic [DIAM_W-1:0]     root_reg;

    logic [SQRT_REM_W-1:0] rem_sh;
    logic [SQRT_REM_W-1:0] trial;
    logic                  fits;

    always_comb
    begin
        rem_sh = {rem_reg[SQRT_REM_W-3:0], val_reg[D2_W-1:D2_W-2]};
        trial  = SQRT_REM_W'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_W'(DIAM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[D2_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[DIAM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sim/polygon_area_centroid_diameter_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// polygon_area_centroid_diameter_tb
// Self-checking testbench of the polygon area, centroid and diameter unit.
// ============================================================================
// Vertices are sent as input transfers, each polygon closed by tlast. A
// behavioural model inside the testbench keeps its own vertex store and
// shoelace sums and predicts one result per closed polygon. Results are
// compared field by field with the oldest prediction. A short table of
// directed polygons comes first, then random polygons of mostly legal size,
// with a few over-long ones: two phases with random idling, one with none.
module polygon_area_centroid_diameter_tb;
    import pacd_pkg::*;

    localparam int MAXV       = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] diameter;
        logic [15:0] cy;
        logic [15:0] cx;
        logic [34:0] area;
    } shape_result_t;

    // One row of the directed table: a vertex, its tlast, and optionally
    // a result typed in by hand.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 last;
        bit                 fixed;
        shape_result_t      res;
    } vertex_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    polygon_area_centroid_diameter #(.MAX_VERTICES(MAXV)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 clk = ~clk;

    // Model state of the polygon being collected.
    longint        poly_x [MAXV];
    longint        poly_y [MAXV];
    int            poly_n;
    bit            poly_over;
    longint        cross_acc, momx_acc, momy_acc;
    shape_result_t pending_shapes[$];
    bit            fixed_flags[$];
    shape_result_t fixed_values[$];

    int errors = 0;
    int sender_idle = 34, receiver_idle = 49;
    int idle_cycles = 0;

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [15:0] round_coord(longint num, longint den);
        longint q;
        q = (2 * magnitude(num) + magnitude(den)) / (2 * magnitude(den));
        if ((num < 0) != (den < 0))
            return q > 32768 ? 16'sh8000 : 16'(-q);
        return q > 32767 ? 16'h7fff : 16'(q);
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r = 0;
        longint b = 64'sd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void add_edge(longint xa, longint ya, longint xb, longint yb);
        longint c = xa * yb - xb * ya;
        cross_acc += c;
        momx_acc  += (xa + xb) * c;
        momy_acc  += (ya + yb) * c;
    endfunction

    function automatic void clear_polygon();
        poly_n = 0; poly_over = 0;
        cross_acc = 0; momx_acc = 0; momy_acc = 0;
    endfunction

    // Advance the model by one accepted vertex; a closed polygon queues
    // its expected result.
    function automatic void model_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                         bit last);
        shape_result_t r;
        longint best = 0, dx, dy, d2;
        if (poly_n >= MAXV)
            poly_over = 1;
        else
        begin
            if (poly_n > 0) add_edge(poly_x[poly_n-1], poly_y[poly_n-1], vx, vy);
            poly_x[poly_n] = vx; poly_y[poly_n] = vy;
            poly_n++;
        end
        if (!last) return;
        r = '0;
        if (poly_n > 0) add_edge(poly_x[poly_n-1], poly_y[poly_n-1], poly_x[0], poly_y[0]);
        if (poly_over)
            r.status = STATUS_OVERFLOW;
        else
        begin
            r.area = magnitude(cross_acc) > 64'h7_ffff_ffff ? '1 : 35'(magnitude(cross_acc));
            for (int i = 0; i < poly_n; i++)
                for (int j = i + 1; j < poly_n; j++)
                begin
                    dx = poly_x[i] - poly_x[j];
                    dy = poly_y[i] - poly_y[j];
                    d2 = dx * dx + dy * dy;
                    if (d2 > best) best = d2;
                end
            r.diameter = 17'(floor_sqrt(best));
            if (poly_n < 3 || cross_acc == 0)
                r.status = STATUS_DEGEN;
            else
            begin
                r.status = STATUS_OK;
                r.cx = round_coord(momx_acc, 3 * cross_acc);
                r.cy = round_coord(momy_acc, 3 * cross_acc);
            end
        end
        pending_shapes.push_back(r);
        clear_polygon();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Result side: random stalls, comparison against the oldest prediction.
    always @(posedge clk)
    begin
        shape_result_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[85:0];
                if (pending_shapes.size() == 0)
                    report_mismatch("unexpected result, status", got.status, -1);
                else
                begin
                    want = pending_shapes.pop_front();
                    if (fixed_flags.pop_front())
                    begin
                        // a hand-typed value must agree with the model as well
                        if (fixed_values[0] != want)
                            report_mismatch("table row disagrees, area", fixed_values[0].area,
                                            want.area);
                        void'(fixed_values.pop_front());
                    end
                    if (got.area != want.area) report_mismatch("twice_area", got.area, want.area);
                    if (got.cx != want.cx)
                        report_mismatch("centroid_x", $signed(got.cx), $signed(want.cx));
                    if (got.cy != want.cy)
                        report_mismatch("centroid_y", $signed(got.cy), $signed(want.cy));
                    if (got.diameter != want.diameter)
                        report_mismatch("diameter", got.diameter, want.diameter);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                end
                if (m_tdata[87:86] != 2'b00) report_mismatch("pad bits", m_tdata[87:86], 0);
            end
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("polygon_area_centroid_diameter: mismatch");
            $finish;
        end
    end

    // Present one vertex and hold it until the transfer happens.
    task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy, bit last);
        while ($urandom_range(99) < sender_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        model_vertex(vx, vy, last);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_polygon();
        int n;
        int pick = $urandom_range(99);
        if (pick < 6)       n = $urandom_range(MAXV + 4, MAXV + 1);   // too many vertices
        else if (pick < 14) n = $urandom_range(2, 1);
        else                n = $urandom_range(MAXV, 3);
        for (int k = 0; k < n; k++)
            send_vertex(rand_coord(), rand_coord(), k == n - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_shapes.size() != 0) @(posedge clk);
    endtask

    vertex_row_t directed_rows[$];

    function automatic void add_row(int vx, int vy, bit last, bit fixed = 0,
                                    shape_result_t res = '0);
        vertex_row_t row;
        row.x = 16'(vx); row.y = 16'(vy); row.last = last; row.fixed = fixed; row.res = res;
        directed_rows.push_back(row);
    endfunction

    initial
    begin
        int sent;
        clear_polygon();
        // single vertex: degenerate, all numbers zero
        add_row(1000, -2000, 1, 1, '{status: STATUS_DEGEN, default: '0});
        // two vertices: degenerate, diameter 5 (the long side of a 3-4-5 triangle)
        add_row(0, 0, 0);
        add_row(3, 4, 1, 1, '{status: STATUS_DEGEN, diameter: 17'd5, default: '0});
        // unit right triangle, counter-clockwise then clockwise
        add_row(0, 0, 0); add_row(16384, 0, 0); add_row(0, 16384, 1);
        add_row(0, 0, 0); add_row(0, 16384, 0); add_row(16384, 0, 1);
        // collinear points: zero area
        add_row(-100, -100, 0); add_row(0, 0, 0); add_row(100, 100, 1);
        // extreme corners: largest area and diameter
        add_row(-32768, -32768, 0); add_row(32767, -32768, 0);
        add_row(32767, 32767, 0); add_row(-32768, 32767, 1);
        // one vertex more than the store holds
        for (int k = 0; k <= MAXV; k++)
            add_row(k * 997 - 8000, (k * k * 131) % 30000 - 15000, k == MAXV, k == MAXV,
                    '{status: STATUS_OVERFLOW, default: '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].last)
            begin
                fixed_flags.push_back(directed_rows[r].fixed);
                if (directed_rows[r].fixed) fixed_values.push_back(directed_rows[r].res);
            end
            send_vertex(directed_rows[r].x, directed_rows[r].y, directed_rows[r].last);
        end
        // sender holds off until every prediction has been answered
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle   = phase == 0 ? 34 : (phase == 1 ? 49 : 0);
            receiver_idle = phase == 0 ? 49 : (phase == 1 ? 34 : 0);
            while (sent < (phase + 1) * 650)
            begin
                automatic int before_n = pending_shapes.size();
                send_random_polygon();
                fixed_flags.push_back(0);
                sent += 9;
                if (pending_shapes.size() == before_n) fixed_flags.pop_back();
            end
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("polygon_area_centroid_diameter: match");
        else
            $display("polygon_area_centroid_diameter: mismatch");
        $finish;
    end
endmodule
